[src/rppd_pkg.sv]
package rppd_pkg;

  localparam logic signed [32:0] NOMINAL_LENGTH = 33'sd163840;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS      = 3'd0,
    CFG_PAYOUT_MIN  = 3'd1,
    CFG_PAYOUT_MAX  = 3'd2,
    CFG_SPEED_LIMIT = 3'd3,
    CFG_DRIVE_MODE  = 3'd4,
    CFG_GAIN_P      = 3'd5,
    CFG_GAIN_D      = 3'd6,
    CFG_FORCE_LIMIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_VELOCITY = 2'd1,
    MODE_FORCE    = 2'd2,
    MODE_SPARE    = 2'd3
  } drive_mode_e;

  typedef struct packed {
    logic signed [31:0] reel_speed;
    logic signed [31:0] reel_angle;
    logic signed [31:0] payout_position;
    logic signed [31:0] payout_speed;
    logic               speed_present;
    logic               readings_present;
    logic        [15:0] time_step;
  } in_t;

  typedef struct packed {
    logic signed [31:0] tether_length;
    logic signed [31:0] measured_speed;
    logic               at_stop;
    logic               rate_limited;
    logic               unavailable;
    logic signed [31:0] angle_out;
    logic signed [31:0] reference_length;
    logic signed [31:0] drive_command;
    logic               command_valid;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_TARGET,
    OP_SATURATE,
    OP_MUL_STEP,
    OP_REFERENCE,
    OP_MUL_P,
    OP_MUL_D,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_accept;
    logic out_free;
  } dp_status_t;

endpackage

[src/rppd_ctrl.sv]
module rppd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rppd_pkg::dp_status_t status_i,
  output rppd_pkg::dp_cmd_t   cmd_o,
  output logic                busy_o
);
  import rppd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TARGET,
    S_SATURATE,
    S_STEP,
    S_REFERENCE,
    S_MUL_P,
    S_MUL_D,
    S_DONE
  } state_e;

  state_e  state_q;
  dp_cmd_t cmd_q;
  logic    busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q.op <= OP_NONE;
      busy_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (status_i.in_accept) begin
            state_q  <= S_TARGET;
            cmd_q.op <= OP_MUL_TARGET;
            busy_q   <= 1'b1;
          end
        end
        S_TARGET: begin
          state_q  <= S_SATURATE;
          cmd_q.op <= OP_SATURATE;
        end
        S_SATURATE: begin
          state_q  <= S_STEP;
          cmd_q.op <= OP_MUL_STEP;
        end
        S_STEP: begin
          state_q  <= S_REFERENCE;
          cmd_q.op <= OP_REFERENCE;
        end
        S_REFERENCE: begin
          state_q  <= S_MUL_P;
          cmd_q.op <= OP_MUL_P;
        end
        S_MUL_P: begin
          state_q  <= S_MUL_D;
          cmd_q.op <= OP_MUL_D;
        end
        S_MUL_D: begin
          state_q  <= S_DONE;
          cmd_q.op <= OP_FINISH;
        end
        S_DONE: begin
          // wait here while the previous result is still held downstream
          if (status_i.out_free) begin
            state_q  <= S_IDLE;
            cmd_q.op <= OP_NONE;
            busy_q   <= 1'b0;
          end
        end
        default: begin
          state_q  <= S_IDLE;
          cmd_q.op <= OP_NONE;
          busy_q   <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o  = cmd_q;
  assign busy_o = busy_q;

endmodule

[src/rppd_datapath.sv]
module rppd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rppd_pkg::dp_cmd_t     cmd_i,
  output rppd_pkg::dp_status_t  status_o,
  input  logic                  in_accept_i,
  input  rppd_pkg::in_t         in_data_i,
  input  logic                  cfg_write_i,
  input  logic [rppd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rppd_pkg::out_t        out_data_o
);
  import rppd_pkg::*;

  // configuration
  logic        [15:0] radius_q;
  logic signed [31:0] pmin_q;
  logic signed [31:0] pmax_q;
  logic        [30:0] speed_lim_q;
  logic        [1:0]  mode_q;
  logic        [30:0] gain_p_q;
  logic        [30:0] gain_d_q;
  logic        [30:0] force_lim_q;

  // working registers
  in_t                in_q;
  logic signed [64:0] prod_q;
  logic signed [48:0] pterm_q;
  logic signed [31:0] target_q;
  logic               limited_q;
  logic               stop_q;
  logic signed [31:0] ref_q;
  logic signed [31:0] refext_q;
  logic               out_valid_q;
  out_t               out_q;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] prod_sh;
  logic signed [31:0] meas;
  logic signed [48:0] lim49;
  logic signed [31:0] lim32;
  logic signed [31:0] tsat;
  logic               tlimited;
  logic               tstop;
  logic signed [31:0] target_d;
  logic signed [32:0] ref_sum;
  logic signed [32:0] ref_hi;
  logic signed [32:0] ref_lo;
  logic signed [49:0] fsum;
  logic signed [49:0] flim50;
  logic signed [31:0] force32;
  logic signed [31:0] cmd;
  logic               cmd_valid;
  logic               out_free;
  logic               out_load;
  out_t               result;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sh0_7FFF_FFFF;
    lo = -33'sh0_8000_0000;
    if (v > hi) begin
      sat32 = hi[31:0];
    end else if (v < lo) begin
      sat32 = lo[31:0];
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 16'd4588;
      pmin_q      <= 32'sd0;
      pmax_q      <= 32'sd65536;
      speed_lim_q <= 31'd32768;
      mode_q      <= MODE_FORCE;
      gain_p_q    <= 31'd13107200;
      gain_d_q    <= 31'd1310720;
      force_lim_q <= 31'd1310720;
    end else if (cfg_write_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS:      radius_q    <= cfg_data_i[15:0];
        CFG_PAYOUT_MIN:  pmin_q      <= signed'(cfg_data_i);
        CFG_PAYOUT_MAX:  pmax_q      <= signed'(cfg_data_i);
        CFG_SPEED_LIMIT: speed_lim_q <= cfg_data_i[30:0];
        CFG_DRIVE_MODE:  mode_q      <= cfg_data_i[1:0];
        CFG_GAIN_P:      gain_p_q    <= cfg_data_i[30:0];
        CFG_GAIN_D:      gain_d_q    <= cfg_data_i[30:0];
        CFG_FORCE_LIMIT: force_lim_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign meas    = in_q.speed_present ? in_q.payout_speed : 32'sd0;
  assign prod_sh = signed'(prod_q[64:16]);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_TARGET: begin
        mul_a = {in_q.reel_speed[31], in_q.reel_speed};
        mul_b = signed'({16'd0, radius_q});
      end
      OP_MUL_STEP: begin
        mul_a = {target_q[31], target_q};
        mul_b = signed'({16'd0, in_q.time_step});
      end
      OP_MUL_P: begin
        mul_a = {ref_q[31], ref_q} - {in_q.payout_position[31], in_q.payout_position};
        mul_b = signed'({1'b0, gain_p_q});
      end
      OP_MUL_D: begin
        mul_a = {target_q[31], target_q} - {meas[31], meas};
        mul_b = signed'({1'b0, gain_d_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rate limit then stop check
  assign lim49 = signed'({18'd0, speed_lim_q});
  assign lim32 = signed'({1'b0, speed_lim_q});

  always_comb begin
    tlimited = 1'b0;
    tsat     = prod_sh[31:0];
    if (prod_sh > lim49) begin
      tsat     = lim32;
      tlimited = 1'b1;
    end else if (prod_sh < -lim49) begin
      tsat     = -lim32;
      tlimited = 1'b1;
    end
    tstop    = 1'b0;
    target_d = tsat;
    if (in_q.payout_position <= pmin_q && tsat < 32'sd0) begin
      target_d = 32'sd0;
      tstop    = 1'b1;
    end else if (in_q.payout_position >= pmax_q && tsat > 32'sd0) begin
      target_d = 32'sd0;
      tstop    = 1'b1;
    end
  end

  // reference: limit to the upper stop first, then raise to the lower one
  assign ref_sum = {refext_q[31], refext_q} + {prod_sh[31], prod_sh[31:0]};
  assign ref_hi  = (ref_sum > signed'({pmax_q[31], pmax_q})) ?
                   signed'({pmax_q[31], pmax_q}) : ref_sum;
  assign ref_lo  = (ref_hi < signed'({pmin_q[31], pmin_q})) ?
                   signed'({pmin_q[31], pmin_q}) : ref_hi;

  // pd force, p term held while the d product lands
  assign fsum   = {pterm_q[48], pterm_q} + {prod_sh[48], prod_sh};
  assign flim50 = signed'({19'd0, force_lim_q});

  always_comb begin
    if (fsum > flim50) begin
      force32 = signed'({1'b0, force_lim_q});
    end else if (fsum < -flim50) begin
      force32 = -signed'({1'b0, force_lim_q});
    end else begin
      force32 = fsum[31:0];
    end
  end

  always_comb begin
    cmd       = 32'sd0;
    cmd_valid = 1'b0;
    case (drive_mode_e'(mode_q))
      MODE_VELOCITY: begin
        cmd       = target_q;
        cmd_valid = 1'b1;
      end
      MODE_FORCE: begin
        cmd       = force32;
        cmd_valid = 1'b1;
      end
      default: begin
        cmd       = 32'sd0;
        cmd_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (!in_q.readings_present) begin
      result.unavailable = 1'b1;
    end else begin
      result.tether_length =
        sat32(NOMINAL_LENGTH + {in_q.payout_position[31], in_q.payout_position});
      result.measured_speed   = meas;
      result.at_stop          = stop_q;
      result.rate_limited     = limited_q;
      result.unavailable      = 1'b0;
      result.angle_out        = in_q.reel_angle;
      result.reference_length = sat32(NOMINAL_LENGTH + {ref_q[31], ref_q});
      result.drive_command    = cmd;
      result.command_valid    = cmd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      in_q <= in_data_i;
    end
    // the product is held between multiplies so a stalled finish still sees it
    if (cmd_i.op inside {OP_MUL_TARGET, OP_MUL_STEP, OP_MUL_P, OP_MUL_D}) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.op == OP_MUL_D) begin
      pterm_q <= prod_sh;
    end
    if (cmd_i.op == OP_SATURATE) begin
      target_q  <= target_d;
      limited_q <= tlimited;
      stop_q    <= tstop;
    end
    if (cmd_i.op == OP_REFERENCE) begin
      ref_q <= ref_lo[31:0];
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refext_q <= 32'sd0;
    end else if (cmd_i.op == OP_REFERENCE && in_q.readings_present) begin
      refext_q <= ref_lo[31:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (cmd_i.op == OP_FINISH) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.in_accept = in_accept_i;
  assign status_o.out_free  = out_free;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

[src/reel_payout_pd_drive.sv]
// an accepted item runs target multiply, saturate, step multiply, reference, p multiply,
// d multiply and finish; one shared multiplier is used four times per item
// the next item is taken once the result is in the output register, even if it is stalled
// reset: configuration returns to its defaults and the reference extension clears to zero
// configuration writes are always ready and take effect in the following cycle
module reel_payout_pd_drive (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rppd_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rppd_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rppd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import rppd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;
  logic       in_accept;

  assign in_stall_o  = busy;
  assign in_accept   = in_valid_i && !busy;
  assign cfg_ready_o = 1'b1;

  rppd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  rppd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after input transfer");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

  // the block frees up only once its result is in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block went idle without a result");

endmodule

[dv/tb_reel_payout_pd_drive.sv]
module tb_reel_payout_pd_drive;
  import rppd_pkg::*;

  localparam int unsigned IdleLimit     = 3000;
  localparam int unsigned SqueezeCycles = 300;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned ShownErrors   = 10;

  typedef struct {
    bit          is_reg;
    cfg_idx_e    idx;
    logic [31:0] value;
    in_t         item;
    bit          typed;
    out_t        want;
  } step_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i  = '0;

  // predictor copy of the configuration and the reference extension
  logic        [15:0] m_radius      = 16'd4588;
  logic signed [31:0] m_pmin        = 32'sd0;
  logic signed [31:0] m_pmax        = 32'sd65536;
  logic        [30:0] m_speed_limit = 31'd32768;
  drive_mode_e        m_mode        = MODE_FORCE;
  logic        [30:0] m_gain_p      = 31'd13107200;
  logic        [30:0] m_gain_d      = 31'd1310720;
  logic        [30:0] m_force_limit = 31'd1310720;
  logic signed [31:0] m_ref_ext     = 32'sd0;

  out_t        due_results[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  bit          calm         = 1'b0;
  bit          squeeze_req  = 1'b0;

  reel_payout_pd_drive dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor of x * k / 2^16
  function automatic logic signed [63:0] q16_mul(logic signed [63:0] x, logic [31:0] k);
    logic signed [95:0] prod;
    prod = x * $signed({1'b0, k});
    return prod >>> 16;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < 64'shFFFF_FFFF_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic out_t drive_step(in_t it);
    logic signed [63:0] target, limit, extn, pos, meas, force_sum, flim, nominal;
    out_t res;
    res = '0;
    if (!it.readings_present) begin
      res.unavailable = 1'b1;
      return res;
    end
    nominal = NOMINAL_LENGTH;
    pos     = it.payout_position;
    limit   = {33'd0, m_speed_limit};
    flim    = {33'd0, m_force_limit};
    target  = q16_mul(it.reel_speed, {16'd0, m_radius});
    if (target > limit) begin
      target = limit;
      res.rate_limited = 1'b1;
    end else if (target < -limit) begin
      target = -limit;
      res.rate_limited = 1'b1;
    end
    // never drive further into a stop
    if (pos <= m_pmin && target < 0) begin
      target = 0;
      res.at_stop = 1'b1;
    end else if (pos >= m_pmax && target > 0) begin
      target = 0;
      res.at_stop = 1'b1;
    end
    extn = m_ref_ext;
    extn = extn + q16_mul(target, {16'd0, it.time_step});
    // upper stop first, so inverted stops settle on the lower one
    if (extn > m_pmax) extn = m_pmax;
    if (extn < m_pmin) extn = m_pmin;
    m_ref_ext = extn[31:0];
    if (it.speed_present) meas = it.payout_speed;
    else meas = 0;
    case (m_mode)
      MODE_VELOCITY: begin
        res.drive_command = target[31:0];
        res.command_valid = 1'b1;
      end
      MODE_FORCE: begin
        force_sum = q16_mul(extn - pos, {1'b0, m_gain_p}) +
                    q16_mul(target - meas, {1'b0, m_gain_d});
        if (force_sum > flim) force_sum = flim;
        if (force_sum < -flim) force_sum = -flim;
        res.drive_command = force_sum[31:0];
        res.command_valid = 1'b1;
      end
      default: ;
    endcase
    res.tether_length    = clip32(nominal + pos);
    res.measured_speed   = meas[31:0];
    res.angle_out        = it.reel_angle;
    res.reference_length = clip32(nominal + extn);
    return res;
  endfunction

  function automatic string describe(out_t r);
    return $sformatf("len %h spd %h stop %b lim %b unav %b ang %h ref %h cmd %h cv %b",
                     r.tether_length, r.measured_speed, r.at_stop, r.rate_limited,
                     r.unavailable, r.angle_out, r.reference_length, r.drive_command,
                     r.command_valid);
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  // for most registers r below 2 picks the top, 2 the bottom, 3 to 6 a typical value
  function automatic logic [31:0] pick_cfg(cfg_idx_e idx, int unsigned r);
    logic [31:0] v;
    v = $urandom;
    case (idx)
      CFG_RADIUS: begin
        if (r < 2) v[15:0] = 16'hFFFF;
        else if (r < 3) v[15:0] = 16'h0000;
        else if (r < 7) v[15:0] = $urandom_range(1000, 20000);
      end
      CFG_PAYOUT_MIN: begin
        if (r < 2) v = 32'h8000_0000;
        else if (r < 7) v = 32'd0 - $urandom_range(0, 131072);
      end
      CFG_PAYOUT_MAX: begin
        if (r < 2) v = 32'h7FFF_FFFF;
        else if (r < 7) v = $urandom_range(0, 131072);
      end
      CFG_DRIVE_MODE: begin
        if (r < 4) v[1:0] = MODE_FORCE;
        else if (r < 6) v[1:0] = MODE_VELOCITY;
      end
      default: begin
        if (r < 2) v[30:0] = '1;
        else if (r < 3) v[30:0] = '0;
        else if (r < 7) v[30:0] = $urandom_range(1, 1 << 22);
      end
    endcase
    return v;
  endfunction

  function automatic in_t pick_item();
    in_t it;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) it.reel_speed = $urandom;
    else if (r == 1) it.reel_speed = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else it.reel_speed = near(32'd0, 1 << 20);
    it.reel_angle = $urandom;
    r = $urandom_range(0, 9);
    // lean on positions sitting at or around the stops
    if (r < 3) it.payout_position = near(m_pmin, 4);
    else if (r < 6) it.payout_position = near(m_pmax, 4);
    else if (r < 7) it.payout_position = $urandom;
    else it.payout_position = near(32'd0, 1 << 17);
    it.payout_speed     = $urandom_range(0, 1) ? $urandom : near(32'd0, 1 << 18);
    it.speed_present    = $urandom_range(0, 1);
    it.readings_present = ($urandom_range(0, 9) != 0);
    it.time_step        = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 16'h0800);
    return it;
  endfunction

  function automatic step_t item_row(logic [31:0] spd_r, logic [31:0] ang, logic [31:0] pos,
                                     logic [31:0] spd_p, logic sp, logic rp, logic [15:0] dt);
    step_t s;
    s.is_reg                = 1'b0;
    s.idx                   = CFG_RADIUS;
    s.value                 = '0;
    s.item.reel_speed       = spd_r;
    s.item.reel_angle       = ang;
    s.item.payout_position  = pos;
    s.item.payout_speed     = spd_p;
    s.item.speed_present    = sp;
    s.item.readings_present = rp;
    s.item.time_step        = dt;
    s.typed                 = 1'b0;
    s.want                  = '0;
    return s;
  endfunction

  function automatic step_t reg_row(cfg_idx_e idx, logic [31:0] v);
    step_t s;
    s        = item_row('0, '0, '0, '0, 1'b0, 1'b0, '0);
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.value  = v;
    return s;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RADIUS:      m_radius      = v[15:0];
      CFG_PAYOUT_MIN:  m_pmin        = v;
      CFG_PAYOUT_MAX:  m_pmax        = v;
      CFG_SPEED_LIMIT: m_speed_limit = v[30:0];
      CFG_DRIVE_MODE:  m_mode        = drive_mode_e'(v[1:0]);
      CFG_GAIN_P:      m_gain_p      = v[30:0];
      CFG_GAIN_D:      m_gain_d      = v[30:0];
      CFG_FORCE_LIMIT: m_force_limit = v[30:0];
      default: ;
    endcase
  endtask

  task automatic send_item(in_t it, bit typed, out_t want);
    out_t predicted;
    cfg_valid_i <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = drive_step(it);
    due_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    step_t plan[$];
    step_t row;
    out_t  known;

    row = item_row(32'h0, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 1'b1, 16'h0);
    row.typed                 = 1'b1;
    row.want                  = '0;
    row.want.tether_length    = 32'sd163840;
    row.want.angle_out        = 32'h1234_5678;
    row.want.reference_length = 32'sd163840;
    row.want.command_valid    = 1'b1;
    plan.push_back(row);
    known = '0;
    known.unavailable = 1'b1;
    row = item_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0,
                   16'hFFFF);
    row.typed = 1'b1;
    row.want  = known;
    plan.push_back(row);
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000, 32'h8000_0000, 1'b1, 1'b1,
                            16'hFFFF));
    plan.push_back(item_row(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            16'hFFFF));
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1,
                            16'hFFFF));
    plan.push_back(item_row(32'h0010_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1,
                            1'b1, 16'hFFFF));
    plan.push_back(item_row(32'hFFFF_0000, 32'h0, 32'h8000, 32'hFFFF_8000, 1'b1, 1'b1, 16'h8000));
    row = item_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0, 16'h0);
    row.typed = 1'b1;
    row.want  = known;
    plan.push_back(row);
    plan.push_back(item_row(32'h0001_0000, 32'h0, 32'h4000, 32'h0, 1'b0, 1'b1, 16'h0001));
    // force sum well past the widest clamp
    plan.push_back(reg_row(CFG_GAIN_P, 32'h7FFF_FFFF));
    plan.push_back(reg_row(CFG_GAIN_D, 32'h7FFF_FFFF));
    plan.push_back(reg_row(CFG_FORCE_LIMIT, 32'h7FFF_FFFF));
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
                            16'hFFFF));
    plan.push_back(item_row(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            16'hFFFF));
    plan.push_back(reg_row(CFG_FORCE_LIMIT, 32'h0));
    plan.push_back(item_row(32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'h1000));
    plan.push_back(reg_row(CFG_DRIVE_MODE, {30'd0, MODE_VELOCITY}));
    plan.push_back(item_row(32'h8000_0000, 32'h0, 32'h8000, 32'h0, 1'b0, 1'b1, 16'h1000));
    plan.push_back(reg_row(CFG_DRIVE_MODE, {30'd0, MODE_NONE}));
    plan.push_back(item_row(32'h0001_0000, 32'h0, 32'h8000, 32'h0, 1'b0, 1'b1, 16'h1000));
    plan.push_back(reg_row(CFG_DRIVE_MODE, {30'd0, MODE_SPARE}));
    plan.push_back(item_row(32'h0001_0000, 32'h0, 32'h8000, 32'h0, 1'b0, 1'b1, 16'h1000));
    // stops the wrong way round
    plan.push_back(reg_row(CFG_PAYOUT_MIN, 32'h0002_0000));
    plan.push_back(reg_row(CFG_PAYOUT_MAX, 32'h0001_0000));
    plan.push_back(item_row(32'h0001_0000, 32'h0, 32'h0001_8000, 32'h0, 1'b1, 1'b1, 16'h4000));
    plan.push_back(reg_row(CFG_RADIUS, 32'hFFFF_FFFF));
    plan.push_back(reg_row(CFG_SPEED_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(reg_row(CFG_PAYOUT_MIN, 32'h8000_0000));
    plan.push_back(reg_row(CFG_PAYOUT_MAX, 32'h7FFF_FFFF));
    plan.push_back(reg_row(CFG_DRIVE_MODE, {30'd0, MODE_FORCE}));
    plan.push_back(reg_row(CFG_GAIN_P, 32'h0));
    plan.push_back(reg_row(CFG_GAIN_D, 32'h0001_0000));
    plan.push_back(reg_row(CFG_FORCE_LIMIT, 32'h7FFF_FFFF));
    // reference length runs into saturation
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'hFFFF));
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'hFFFF));
    plan.push_back(item_row(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
                            16'hFFFF));
    plan.push_back(reg_row(CFG_RADIUS, 32'h0));
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'hFFFF));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        write_reg(cfg_idx_e'(r), pick_cfg(cfg_idx_e'(r),
                  (p == 0) ? 0 : (p == 1) ? 2 : $urandom_range(0, 9)));
      end
      calm = (p == 4);
      if (p == 2) squeeze_req = 1'b1;
      repeat (PhaseItems) send_item(pick_item(), 1'b0, '0);
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[reel_payout_pd_drive] OK");
    end else begin
      $display("[reel_payout_pd_drive] ERROR");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (SqueezeCycles) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 32);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors) begin
          $display("result %0d: transfer with nothing expected: %s", results_seen,
                   describe(out_data_o));
        end
      end else begin
        want = due_results.pop_front();
        if (out_data_o.tether_length    !== want.tether_length    ||
            out_data_o.measured_speed   !== want.measured_speed   ||
            out_data_o.at_stop          !== want.at_stop          ||
            out_data_o.rate_limited     !== want.rate_limited     ||
            out_data_o.unavailable      !== want.unavailable      ||
            out_data_o.angle_out        !== want.angle_out        ||
            out_data_o.reference_length !== want.reference_length ||
            out_data_o.drive_command    !== want.drive_command    ||
            out_data_o.command_valid    !== want.command_valid) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("result %0d expected: %s", results_seen, describe(want));
            $display("result %0d actual:   %s", results_seen, describe(out_data_o));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("[reel_payout_pd_drive] ERROR");
      $finish;
    end
  end

endmodule
